@@ hw/rtl/rct_pkg.sv @@
// Shared types and constants for the reservation conflict table.
package rct_pkg;

    localparam int ID_W   = 32;
    localparam int PRI_W  = 4;
    localparam int TS_W   = 32;
    localparam int MASK_W = 64;
    localparam int WIN_W  = 32;

    typedef enum logic [1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_UPDATE     = 2'd1,
        KIND_UNREGISTER = 2'd2,
        KIND_QUERY      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_FETCH,
        S_MOVE,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic hit;
        logic blocked;
    } t_cmp_res;

endpackage

@@ hw/rtl/rct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rct_cmp.sv @@
// Shared compare unit: id match and blocking test of one stored entry.
module rct_cmp #(
    parameter int MASK_BITS = 64
) (
    input  logic [rct_pkg::ID_W-1:0]  i_entry_id,
    input  logic [rct_pkg::PRI_W-1:0] i_entry_pri,
    input  logic [rct_pkg::TS_W-1:0]  i_entry_ts,
    input  logic [MASK_BITS-1:0]      i_entry_mask,
    input  logic [rct_pkg::ID_W-1:0]  i_q_id,
    input  logic [rct_pkg::PRI_W-1:0] i_q_pri,
    input  logic [rct_pkg::TS_W-1:0]  i_q_ts,
    input  logic [MASK_BITS-1:0]      i_q_mask,
    input  logic [rct_pkg::WIN_W-1:0] i_window,
    output rct_pkg::t_cmp_res         o_res
);

    import rct_pkg::*;

    logic            overlap;
    logic            older_in_window;
    logic [TS_W-1:0] age;

    assign age             = i_q_ts - i_entry_ts;
    assign overlap         = |(i_entry_mask & i_q_mask);
    assign older_in_window = (i_entry_ts < i_q_ts) && (age < i_window);

    always_comb begin
        o_res.hit     = (i_entry_id == i_q_id);
        o_res.blocked = !o_res.hit && overlap &&
                        ((i_entry_pri > i_q_pri) ||
                         ((i_entry_pri == i_q_pri) && older_in_window));
    end

endmodule

@@ hw/rtl/reservation_conflict_table.sv @@
// Reservation conflict table: sequencer, entry RAM and shared compare unit.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+---------------------------------------
//  command  | start, busy                    | i_kind, i_intent_id, i_priority_req,
//           |                                | i_timestamp, i_resource_mask
//  result   | o_result_valid (one cycle)     | o_status, o_may_proceed
//  config   | i_cfg_valid, o_cfg_ready       | i_window_seconds
//
// Register does not raise busy; its result is registered and appears in the next cycle.
// Update and unregister scan for the first id match; update rewrites it, unregister moves the
// last entry into its slot; a query finds its entry, then scans all entries against the compare
// unit until one blocks. The single read port of the entry RAM reads one entry per cycle.
// Reset clears the entry count and sets the window to 60; entries need no clearing pass.
// The result strobe lasts exactly one cycle and the receiver cannot stall it.
module reservation_conflict_table #(
    parameter int TABLE_DEPTH    = 16,
    parameter int RESOURCE_COUNT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_kind,
    input  logic [rct_pkg::ID_W-1:0]    i_intent_id,
    input  logic [rct_pkg::PRI_W-1:0]   i_priority_req,
    input  logic [rct_pkg::TS_W-1:0]    i_timestamp,
    input  logic [rct_pkg::MASK_W-1:0]  i_resource_mask,
    output logic                        o_result_valid,
    output logic [1:0]                  o_status,
    output logic                        o_may_proceed,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rct_pkg::WIN_W-1:0]   i_window_seconds
);

    import rct_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RC = RESOURCE_COUNT;
    localparam int EW = ID_W + PRI_W + TS_W + RC;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_dv, n_dv;
    logic [IW-1:0]   r_didx, n_didx;
    logic [IW-1:0]   r_hit_idx, n_hit_idx;
    t_kind           r_kind, n_kind;
    logic [ID_W-1:0] r_id, n_id;
    logic [PRI_W-1:0] r_pri, n_pri;
    logic [TS_W-1:0] r_ts, n_ts;
    logic [RC-1:0]   r_mask, n_mask;
    logic            r_strobe, n_strobe;
    t_status         r_status, n_status;
    logic            r_proceed, n_proceed;
    logic [WIN_W-1:0] r_window;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    logic [ID_W-1:0] rd_id;
    logic [PRI_W-1:0] rd_pri;
    logic [TS_W-1:0] rd_ts;
    logic [RC-1:0]   rd_mask;
    t_cmp_res        cmp;
    logic [CW-1:0]   last;

    assign rd_id   = ram_rdata[EW-1 -: ID_W];
    assign rd_pri  = ram_rdata[EW-ID_W-1 -: PRI_W];
    assign rd_ts   = ram_rdata[RC+TS_W-1 -: TS_W];
    assign rd_mask = ram_rdata[RC-1:0];
    assign last    = r_count - CW'(1);

    rct_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rct_cmp #(
        .MASK_BITS (RC)
    ) u_cmp (
        .i_entry_id   (rd_id),
        .i_entry_pri  (rd_pri),
        .i_entry_ts   (rd_ts),
        .i_entry_mask (rd_mask),
        .i_q_id       (r_id),
        .i_q_pri      (r_pri),
        .i_q_ts       (r_ts),
        .i_q_mask     (r_mask),
        .i_window     (r_window),
        .o_res        (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
            r_window <= WIN_W'(60);
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_window_seconds;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_didx    <= n_didx;
        r_hit_idx <= n_hit_idx;
        r_kind    <= n_kind;
        r_id      <= n_id;
        r_pri     <= n_pri;
        r_ts      <= n_ts;
        r_mask    <= n_mask;
        r_status  <= n_status;
        r_proceed <= n_proceed;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_dv      = 1'b0;
        n_didx    = r_didx;
        n_hit_idx = r_hit_idx;
        n_kind    = r_kind;
        n_id      = r_id;
        n_pri     = r_pri;
        n_ts      = r_ts;
        n_mask    = r_mask;
        n_strobe  = 1'b0;
        n_status  = r_status;
        n_proceed = r_proceed;
        ram_we    = 1'b0;
        ram_waddr = r_hit_idx;
        ram_wdata = {r_id, r_pri, r_ts, r_mask};
        ram_raddr = r_idx[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = t_kind'(i_kind);
                    n_id   = i_intent_id;
                    n_pri  = i_priority_req;
                    n_ts   = i_timestamp;
                    n_mask = i_resource_mask[RC-1:0];
                    n_idx  = '0;
                    if (t_kind'(i_kind) == KIND_REGISTER) begin
                        n_strobe  = 1'b1;
                        n_proceed = 1'b0;
                        if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_status  = STAT_DONE;
                            ram_we    = 1'b1;
                            ram_waddr = r_count[IW-1:0];
                            ram_wdata = {i_intent_id, i_priority_req, i_timestamp,
                                         i_resource_mask[RC-1:0]};
                            n_count   = r_count + CW'(1);
                        end
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                if (r_dv && cmp.hit) begin
                    case (r_kind)
                        KIND_UPDATE: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_didx;
                            n_state   = S_IDLE;
                            n_strobe  = 1'b1;
                            n_status  = STAT_DONE;
                            n_proceed = 1'b0;
                        end
                        KIND_UNREGISTER: begin
                            n_hit_idx = r_didx;
                            n_state   = S_FETCH;
                        end
                        default: begin
                            n_pri   = rd_pri;
                            n_ts    = rd_ts;
                            n_mask  = rd_mask;
                            n_idx   = '0;
                            n_state = S_CHECK;
                        end
                    endcase
                end else if (r_idx < r_count) begin
                    n_idx  = r_idx + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_idx[IW-1:0];
                end else if (!r_dv) begin
                    n_state   = S_IDLE;
                    n_strobe  = 1'b1;
                    n_status  = STAT_NOT_FOUND;
                    n_proceed = 1'b0;
                end
            end
            S_FETCH: begin
                ram_raddr = last[IW-1:0];
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                ram_we    = 1'b1;
                ram_waddr = r_hit_idx;
                ram_wdata = ram_rdata;
                n_count   = last;
                n_state   = S_IDLE;
                n_strobe  = 1'b1;
                n_status  = STAT_DONE;
                n_proceed = 1'b0;
            end
            S_CHECK: begin
                if (r_dv && cmp.blocked) begin
                    n_state   = S_IDLE;
                    n_strobe  = 1'b1;
                    n_status  = STAT_DONE;
                    n_proceed = 1'b0;
                end else if (r_idx < r_count) begin
                    n_idx  = r_idx + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_idx[IW-1:0];
                end else if (!r_dv) begin
                    n_state   = S_IDLE;
                    n_strobe  = 1'b1;
                    n_status  = STAT_DONE;
                    n_proceed = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_strobe;
    assign o_status       = r_status;
    assign o_may_proceed  = r_proceed;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_proceed_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_may_proceed) |-> (r_status == STAT_DONE))
        else $error("proceed reported with a failing status");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (t_kind'(i_kind) != KIND_REGISTER)) |=> busy)
        else $error("search command did not raise busy");

    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !busy) |-> (start && (t_kind'(i_kind) == KIND_REGISTER)))
        else $error("table written while idle without a register command");

    a_unreg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=> (r_count == $past(last)))
        else $error("unregister did not shrink the table by one");

endmodule
